// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, disabled while reset is active.
`define CHK_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
        else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
    lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/core/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg
// Types and constants for the continued fraction term generator.
// ----------------------------------------------------------------------------
package cft_pkg;

    localparam int VALUE_BITS = 31;
    localparam int CFG_W      = 7;
    localparam int DIV_CNT_W  = $clog2(VALUE_BITS);

    localparam logic [CFG_W-1:0] MAX_TERMS_RESET = CFG_W'(20);
    localparam logic [CFG_W-1:0] TERM_LIMIT      = CFG_W'(64);

    typedef logic [VALUE_BITS-1:0] cft_value_t;

    typedef struct packed {
        cft_value_t numerator;
        cft_value_t denominator;
    } cft_in_t;

    typedef struct packed {
        cft_value_t term;
        logic       last_term;
    } cft_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT
    } cft_state_t;

endpackage

// File: rtl/core/cft_divider.sv
// ----------------------------------------------------------------------------
// cft_divider
// Restoring divider, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module cft_divider
    import cft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  cft_value_t dividend,
    input  cft_value_t divisor,
    output logic       done,
    output cft_value_t quotient,
    output cft_value_t remainder
);

    logic                 run_reg;
    logic                 run_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    cft_value_t           rem_reg;
    cft_value_t           rem_next;
    cft_value_t           quo_reg;
    cft_value_t           quo_next;
    cft_value_t           dsr_reg;
    cft_value_t           dsr_next;
    logic [VALUE_BITS:0]  trial;
    logic [VALUE_BITS:0]  diff;

    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            if (!diff[VALUE_BITS])
            begin
                rem_next = diff[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(VALUE_BITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/continued_fraction_terms.sv
// ----------------------------------------------------------------------------
// continued_fraction_terms
// Euclid continued fraction expansion of numerator / denominator.
//
//   channel   signals                       handshake
//   operand   start, busy, operand          start & !busy
//   result    result_valid, result          strobe, one cycle, no stall
//   config    cfg_valid, cfg_ready, cfg_data valid & ready (max_terms)
//
// Each term takes a launch step, a run in the bit-serial divider that all
// terms share, and a step to take its quotient and remainder.
// An item that yields no term leaves the sequencer idle.
// Reset clears the sequencer and sets max_terms to 20.
// busy stays high until the last term's beat; results cannot be held off.
// ----------------------------------------------------------------------------
module continued_fraction_terms
    import cft_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cft_in_t          operand,
    output logic             result_valid,
    output cft_out_t         result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    cft_state_t       state_reg;
    cft_state_t       state_next;
    logic [CFG_W-1:0] max_terms_reg;
    logic [CFG_W-1:0] max_terms_next;
    logic [CFG_W-1:0] limit_reg;
    logic [CFG_W-1:0] limit_next;
    logic [CFG_W-1:0] count_reg;
    logic [CFG_W-1:0] count_next;
    cft_value_t       dividend_reg;
    cft_value_t       dividend_next;
    cft_value_t       divisor_reg;
    cft_value_t       divisor_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    cft_out_t         result_reg;
    cft_out_t         result_next;

    logic             accept;
    logic             div_start;
    logic             div_done;
    cft_value_t       div_quotient;
    cft_value_t       div_remainder;
    logic [CFG_W-1:0] limit_sat;
    logic             empty_item;
    logic             last;

    cft_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dividend_reg),
        .divisor   (divisor_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign accept     = start && (state_reg == ST_IDLE);
    assign limit_sat  = (max_terms_reg > TERM_LIMIT) ? TERM_LIMIT : max_terms_reg;
    assign empty_item = (operand.denominator == '0) || (limit_sat == '0);
    assign count_next = (state_reg == ST_IDLE) ? '0
                      : (div_done ? count_reg + 1'b1 : count_reg);
    assign last       = (div_remainder == '0) || (count_next >= limit_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !empty_item)
                begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    state_next = last ? ST_IDLE : ST_LAUNCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_LAUNCH);
    end

    always_comb
    begin
        max_terms_next    = max_terms_reg;
        limit_next        = limit_reg;
        dividend_next     = dividend_reg;
        divisor_next      = divisor_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        if (cfg_valid && cfg_ready)
        begin
            max_terms_next = cfg_data;
        end
        if (accept)
        begin
            limit_next    = limit_sat;
            dividend_next = operand.numerator;
            divisor_next  = operand.denominator;
        end
        if ((state_reg == ST_WAIT) && div_done)
        begin
            result_valid_next     = 1'b1;
            result_next.term      = div_quotient;
            result_next.last_term = last;
            dividend_next         = divisor_reg;
            divisor_next          = div_remainder;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            max_terms_reg    <= MAX_TERMS_RESET;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            max_terms_reg    <= max_terms_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg    <= limit_next;
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/core/cft_checker.sv
// ----------------------------------------------------------------------------
// cft_checker
// Port-level checks for continued_fraction_terms, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cft_checker
    import cft_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             result_valid,
    input  cft_out_t         result
);

    `CHK_ASSERT(a_more_terms_busy, clk, rst_n, result_valid && !result.last_term |-> busy, "early beat while idle")
    `CHK_ASSERT(a_beats_spaced, clk, rst_n, result_valid |=> !result_valid, "two result beats in a row")
    `CHK_ASSERT(a_no_beat_after_start, clk, rst_n, start && !busy |=> !result_valid, "beat after accept")
    `CHK_ASSERT(a_end_on_last, clk, rst_n, $fell(busy) |-> result_valid && result.last_term, "no last beat")

endmodule

bind continued_fraction_terms cft_checker u_cft_checker (.*);

// File: verif/continued_fraction_terms_test.sv
// ----------------------------------------------------------------------------
// continued_fraction_terms_test
// Drives numerator/denominator pairs into the term generator and checks every
// term beat against a Euclid expansion kept in the bench. It runs directed
// edge cases, then random phases under several max_terms settings, including
// zero and values above the cap. Random start gaps fall at any point of the
// work on an item.
// ----------------------------------------------------------------------------
module continued_fraction_terms_test;
    import cft_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam cft_value_t VALUE_MAX = {VALUE_BITS{1'b1}};
    localparam cft_value_t FIB_46 = 31'd1836311903;
    localparam cft_value_t FIB_45 = 31'd1134903170;

    class cf_term_board;
        logic [CFG_W-1:0] term_cap;
        cft_out_t         expected_terms[$];

        function new();
            term_cap = MAX_TERMS_RESET;
        endfunction

        function void set_cap(logic [CFG_W-1:0] cap);
            term_cap = cap;
        endfunction

        function int pending();
            return expected_terms.size();
        endfunction

        function void note_operand(cft_in_t op);
            cft_value_t       dividend;
            cft_value_t       divisor;
            cft_value_t       rem;
            cft_out_t         beat;
            logic [CFG_W-1:0] limit;
            int               count;
            bit               done;
            limit = (term_cap > TERM_LIMIT) ? TERM_LIMIT : term_cap;
            dividend = op.numerator;
            divisor = op.denominator;
            count = 0;
            done = (divisor == '0) || (limit == '0);
            while (!done) begin
                rem = dividend % divisor;
                beat.term = dividend / divisor;
                dividend = divisor;
                divisor = rem;
                count++;
                done = (rem == '0) || (count >= int'(limit));
                beat.last_term = done;
                expected_terms.push_back(beat);
            end
        endfunction

        function string check_term(cft_out_t got);
            cft_out_t want;
            string    msg;
            msg = "";
            if (expected_terms.size() == 0)
                return $sformatf("unexpected term %0d last_term %0b", got.term, got.last_term);
            want = expected_terms.pop_front();
            if (got.term !== want.term)
                msg = $sformatf("term %0d, expected %0d", got.term, want.term);
            if (got.last_term !== want.last_term)
                msg = {msg, (msg == "") ? "" : "; ",
                       $sformatf("last_term %0b, expected %0b", got.last_term,
                                 want.last_term)};
            return msg;
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cft_in_t          operand = '0;
    logic             result_valid;
    cft_out_t         result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    cf_term_board sb = new();
    int           error_count = 0;
    int           quiet_cycles = 0;
    bit           idle_on = 1'b1;

    continued_fraction_terms DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operand      (operand),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : term_monitor
        string msg;
        if (rst_n && result_valid) begin
            msg = sb.check_term(result);
            if (msg != "")
                report_mismatch(msg);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(cft_in_t op);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(99) < 25)
            gap = $urandom_range(1, 150);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operand <= op;
        do
            @(posedge clk);
        while (busy);
        sb.note_operand(op);
    endtask

    task automatic send_pair(cft_value_t num, cft_value_t den);
        cft_in_t op;
        op.numerator = num;
        op.denominator = den;
        send_item(op);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_cap(int cap);
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(cap);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_cap(CFG_W'(cap));
    endtask

    function automatic cft_in_t rand_operand();
        cft_in_t    op;
        cft_value_t fa;
        cft_value_t fb;
        cft_value_t fsum;
        int         kind;
        kind = $urandom_range(99);
        op.numerator = cft_value_t'($urandom());
        op.denominator = cft_value_t'($urandom());
        if (kind < 4) begin
            op.denominator = '0;
        end else if (kind < 8) begin
            op.numerator = '0;
        end else if (kind < 22) begin
            fa = 31'd1;
            fb = 31'd1;
            repeat ($urandom_range(1, 44)) begin
                fsum = fa + fb;
                fa = fb;
                fb = fsum;
            end
            op.numerator = $urandom_range(1) ? fb : fa;
            op.denominator = (op.numerator == fb) ? fa : fb;
        end else if (kind < 45) begin
            op.numerator = cft_value_t'($urandom_range(1, 1000));
            op.denominator = cft_value_t'($urandom_range(1, 1000));
        end else if (kind < 65) begin
            op.denominator = cft_value_t'($urandom_range(1, 65535));
        end
        return op;
    endfunction

    initial
    begin
        int caps[8];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pair('0, '0);
        send_pair(VALUE_MAX, '0);
        send_pair('0, 31'd5);
        send_pair('0, VALUE_MAX);
        send_pair(VALUE_MAX, 31'd1);
        send_pair(31'd1, VALUE_MAX);
        send_pair(VALUE_MAX, VALUE_MAX);
        send_pair(31'd415, 31'd93);
        send_pair(FIB_46, FIB_45);
        drain();
        write_cap(64);
        send_pair(FIB_46, FIB_45);
        send_pair(VALUE_MAX, VALUE_MAX - 1);
        drain();
        write_cap(127);
        send_pair(FIB_46, FIB_45);
        drain();
        write_cap(1);
        send_pair(31'd415, 31'd93);
        send_pair('0, 31'd7);
        send_pair(31'd7, '0);
        drain();
        write_cap(0);
        send_pair(31'd415, 31'd93);
        send_pair(31'd5, 31'd3);
        drain();
        write_cap(65);
        send_pair(FIB_46, FIB_45);
        send_pair(VALUE_MAX, 31'd2);

        caps = '{64, 0, 1, 127, 2, 0, 64, 20};
        caps[1] = $urandom_range(1, 64);
        caps[5] = $urandom_range(1, 64);
        for (int p = 0; p < 8; p++) begin
            drain();
            write_cap(caps[p]);
            idle_on = (p != 3);
            for (int i = 0; i < 38; i++)
                send_item(rand_operand());
        end
        drain();
        write_cap(0);
        for (int i = 0; i < 6; i++)
            send_item(rand_operand());

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d expected terms never arrived", sb.pending()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
